// ===== rtl/hssd_pkg.sv =====
// Package for the sequence symbol decoder: item structs, codes, limits.
// No dependencies; used by every module of the block.
`default_nettype none
package hssd_pkg;
	localparam int TableDepth  = 256;
	localparam int MaxCodeBits = 16;
	localparam int AccW        = 16;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;
	localparam logic [1:0] CMD_BIT   = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOCODE = 2'd1;
	localparam logic [1:0] ST_IDLE   = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  entry_symbol;
		logic [4:0]  entry_length;
		logic [15:0] entry_code;
		logic [15:0] sequence_count;
		logic        code_bit;
	} in_item_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic [1:0] status;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic prep;
		logic scan;
		logic emit;
	} ctl_t;

	typedef struct packed {
		logic seq_zero;
		logic scan_last;
		logic need_out;
		logic out_free;
	} stat_t;
endpackage
`default_nettype wire

// ===== rtl/huffman_sequence_symbol_decoder.sv =====
// Top level of the sequence symbol decoder: controller plus datapath.
// Depends on hssd_pkg, hssd_ctrl and hssd_datapath.
//
// Input channel (in_valid/in_stall/in_item) takes clear, load, start and
// code-bit items. Clear, load and start finish in the cycle they are taken.
// A code bit with a sequence pending holds the input through a setup
// state, a scan of the code table reading one entry per cycle from its
// memory port, a compare state and an emit state. A code bit with no
// sequence pending holds the input through the setup and emit states only.
// At most one result item follows, registered at the end of the emit cycle.
// Results sit in an output register (out_valid/out_stall/out_item); the
// next item is taken while a result waits. If a result is ready while the
// previous one is still stalled, the block holds in its emit cycle, and the
// input with it, until the output register is free.
// cfg_valid/cfg_ready writes end_symbol; cfg_ready is always high.
// Reset clears all table valid bits, the code, the sequence count and
// end_symbol at once; no clearing pass is needed.
`default_nettype none
module huffman_sequence_symbol_decoder import hssd_pkg::*; #(
	parameter int TABLE_DEPTH   = TableDepth,
	parameter int MAX_CODE_BITS = MaxCodeBits
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_item,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_item,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data
);
	ctl_t  ctl;
	stat_t stat;

	assign cfg_ready = 1'b1;

	hssd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_bit   (in_item.command == CMD_BIT),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	hssd_datapath #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.ctl       (ctl),
		.stat      (stat),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);
endmodule
`default_nettype wire

// ===== rtl/hssd_datapath.sv =====
// Datapath: code table memory, valid bits, accumulator, counters, output register.
// Depends on hssd_pkg; driven by hssd_ctrl.
`default_nettype none
module hssd_datapath import hssd_pkg::*; #(
	parameter int TABLE_DEPTH   = TableDepth,
	parameter int MAX_CODE_BITS = MaxCodeBits
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  in_item,
	input  wire ctl_t      ctl,
	output stat_t          stat,
	input  wire logic      cfg_we,
	input  wire logic [7:0] cfg_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_item
);
	localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [4:0]      len_mem [TABLE_DEPTH];
	logic [AccW-1:0] val_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [AccW-1:0] acc_q;
	logic [4:0]      bits_q;
	logic [15:0]     seq_q;
	logic [7:0]      end_q;
	logic            bit_q, idle_q, found_q;
	logic [SW-1:0]   idx_q, hit_q, idx_s1;
	logic            rdv_s1, vld_s1;
	logic [4:0]      len_s1;
	logic [AccW-1:0] val_s1;
	logic            match, load_ok, nocode, is_end;
	logic [SW-1:0]   wr_idx;

	assign load_ok = 32'(in_item.entry_symbol) < TABLE_DEPTH;
	assign wr_idx  = SW'(in_item.entry_symbol);
	assign match   = rdv_s1 && vld_s1 && len_s1 == bits_q && val_s1 == acc_q;
	assign nocode  = bits_q >= 5'(MAX_CODE_BITS);
	assign is_end  = 8'(hit_q) == end_q;

	assign stat.seq_zero  = seq_q == 16'd0;
	assign stat.scan_last = idx_q == SW'(TABLE_DEPTH - 1);
	assign stat.need_out  = idle_q || found_q || nocode;
	assign stat.out_free  = !out_valid || !out_stall;

	always_ff @(posedge clk) begin
		if (ctl.accept && in_item.command == CMD_LOAD && load_ok) begin
			len_mem[wr_idx] <= in_item.entry_length;
			val_mem[wr_idx] <= in_item.entry_code;
		end
		len_s1 <= len_mem[idx_q];
		val_s1 <= val_mem[idx_q];
		vld_s1 <= valid_q[idx_q];
		idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			acc_q     <= '0;
			bits_q    <= '0;
			seq_q     <= '0;
			end_q     <= '0;
			bit_q     <= 1'b0;
			idle_q    <= 1'b0;
			found_q   <= 1'b0;
			idx_q     <= '0;
			hit_q     <= '0;
			rdv_s1    <= 1'b0;
			out_valid <= 1'b0;
			out_item  <= '0;
		end else begin
			rdv_s1 <= ctl.scan;
			if (cfg_we) end_q <= cfg_data;
			if (ctl.emit) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			if (ctl.accept) begin
				case (in_item.command)
					CMD_CLEAR: begin
						valid_q <= '0;
						acc_q   <= '0;
						bits_q  <= '0;
					end
					CMD_LOAD: if (load_ok) valid_q[wr_idx] <= 1'b1;
					CMD_START: begin
						seq_q  <= in_item.sequence_count;
						acc_q  <= '0;
						bits_q <= '0;
					end
					default: bit_q <= in_item.code_bit;
				endcase
			end
			if (ctl.prep) begin
				idle_q  <= stat.seq_zero;
				found_q <= 1'b0;
				idx_q   <= '0;
				if (!stat.seq_zero) begin
					acc_q  <= {acc_q[AccW-2:0], bit_q};
					bits_q <= bits_q + 5'd1;
				end
			end
			if (ctl.scan && !stat.scan_last) idx_q <= idx_q + SW'(1);
			if (match) begin
				found_q <= 1'b1;
				hit_q   <= idx_s1;
			end
			if (ctl.emit) begin
				if (idle_q) begin
					out_item <= '{symbol: 8'd0, status: ST_IDLE, last: 1'b0};
				end else if (found_q) begin
					acc_q  <= '0;
					bits_q <= '0;
					if (is_end) seq_q <= seq_q - 16'd1;
					out_item <= '{symbol: 8'(hit_q), status: ST_OK,
						last: is_end && seq_q == 16'd1};
				end else begin
					acc_q  <= '0;
					bits_q <= '0;
					out_item <= '{symbol: 8'd0, status: ST_NOCODE, last: 1'b0};
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/hssd_ctrl.sv =====
// Controller: sequences input acceptance, table scan and result emission.
// Depends on hssd_pkg; drives hssd_datapath.
`default_nettype none
module hssd_ctrl import hssd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire logic  in_bit,
	output logic       in_stall,
	input  wire stat_t stat,
	output ctl_t       ctl
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_TAIL = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0] state_q, state_d;

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		case (state_q)
			S_IDLE: begin
				ctl.accept = in_valid;
				if (in_valid && in_bit) state_d = S_PREP;
			end
			S_PREP: begin
				ctl.prep = 1'b1;
				state_d  = stat.seq_zero ? S_EMIT : S_SCAN;
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (stat.scan_last) state_d = S_TAIL;
			end
			S_TAIL: state_d = S_EMIT;
			S_EMIT: begin
				if (!stat.need_out) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

// ===== rtl/hssd_checker.sv =====
// Port-level checker for the sequence symbol decoder, bound to the top level.
// Depends on hssd_pkg.
`default_nettype none
module hssd_checker import hssd_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire in_item_t  in_item,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_item
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");
	a_bit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.command == CMD_BIT |=> in_stall)
		else $error("code bit not held for table scan");
	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last |-> out_item.status == ST_OK)
		else $error("last on error result");
	a_err_sym: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_OK |-> out_item.symbol == 8'd0)
		else $error("symbol set on error result");
endmodule

bind huffman_sequence_symbol_decoder hssd_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
`default_nettype wire
